/* hdl/timed_pick_place_sequencer_top_macros.svh */
// Assertion macros for the timed pick-and-place sequencer checker.
// Used by files that assert; expects signals named clock and reset in scope.
`ifndef TIMED_PICK_PLACE_SEQUENCER_TOP_MACROS_SVH
`define TIMED_PICK_PLACE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPPS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define TPPS_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* hdl/tpps_pkg.sv */
// Shared types, codes and helpers for the timed pick-and-place sequencer.
// No dependencies; imported by every module of the block.
package tpps_pkg;

   localparam int CoordW = 16;
   localparam int MsW    = 16;
   localparam int PhaseW = 13;
   localparam int PhNumW = 4;
   localparam int CsrIdxW = 3;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_STARTUP_WAIT   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_PICK_MOVE      = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SERVO_MOVE     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_MAGNET_SETTLE  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_MAGNET_RELEASE = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_PLACE_MOVE     = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_HOME_RETURN    = 3'd6;

   // Register values after reset, in milliseconds.
   localparam logic [MsW-1:0] STARTUP_WAIT_RST   = 16'd2000;
   localparam logic [MsW-1:0] PICK_MOVE_RST      = 16'd6500;
   localparam logic [MsW-1:0] SERVO_MOVE_RST     = 16'd1000;
   localparam logic [MsW-1:0] MAGNET_SETTLE_RST  = 16'd1000;
   localparam logic [MsW-1:0] MAGNET_RELEASE_RST = 16'd300;
   localparam logic [MsW-1:0] PLACE_MOVE_RST     = 16'd5000;
   localparam logic [MsW-1:0] HOME_RETURN_RST    = 16'd1000;

   // Action codes reported with each result.
   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_MOVE       = 3'd1,
      ACT_SERVO_LOW  = 3'd2,
      ACT_SERVO_HIGH = 3'd3,
      ACT_MAGNET_ON  = 3'd4,
      ACT_MAGNET_OFF = 3'd5,
      ACT_HOME       = 3'd6
   } act_type;

   // Sequence phases, one-hot. The set bit position is the phase number.
   typedef enum logic [PhaseW-1:0] {
      PH_STARTUP     = 13'b0000000000001,
      PH_IDLE        = 13'b0000000000010,
      PH_TO_PICK     = 13'b0000000000100,
      PH_PICK_AT     = 13'b0000000001000,
      PH_LOWER_PICK  = 13'b0000000010000,
      PH_MAG_SETTLE  = 13'b0000000100000,
      PH_RAISE_PICK  = 13'b0000001000000,
      PH_TO_PLACE    = 13'b0000010000000,
      PH_PLACE_AT    = 13'b0000100000000,
      PH_LOWER_PLACE = 13'b0001000000000,
      PH_MAG_RELEASE = 13'b0010000000000,
      PH_RAISE_PLACE = 13'b0100000000000,
      PH_TO_HOME     = 13'b1000000000000
   } phase_type;

   // Timing configuration as seen by the sequencer core.
   typedef struct packed {
      logic [MsW-1:0] startup_wait_ms;
      logic [MsW-1:0] pick_move_ms;
      logic [MsW-1:0] servo_move_ms;
      logic [MsW-1:0] magnet_settle_ms;
      logic [MsW-1:0] magnet_release_ms;
      logic [MsW-1:0] place_move_ms;
      logic [MsW-1:0] home_return_ms;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      act_type                   action;
      logic signed [CoordW-1:0]  target_x;
      logic signed [CoordW-1:0]  target_y;
      logic [PhNumW-1:0]         phase;
      logic                      ready_res;
   } res_type;

   // Turns a one-hot phase into its phase number.
   function automatic logic [PhNumW-1:0] phase_num(input phase_type ph);
      logic [PhNumW-1:0] num;
      num = '0;
      for (int i = 0; i < PhaseW; i++) begin
         if (ph[i]) begin
            num = num | PhNumW'(i);
         end
      end
      return num;
   endfunction

endpackage

/* hdl/tpps_csr.sv */
// Timing configuration registers of the pick-and-place sequencer.
// Depends on tpps_pkg for register indexes and reset values.
module tpps_csr import tpps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [MsW-1:0]     csr_wdata,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STARTUP_WAIT:   cfg_in.startup_wait_ms   = csr_wdata;
            CSR_PICK_MOVE:      cfg_in.pick_move_ms      = csr_wdata;
            CSR_SERVO_MOVE:     cfg_in.servo_move_ms     = csr_wdata;
            CSR_MAGNET_SETTLE:  cfg_in.magnet_settle_ms  = csr_wdata;
            CSR_MAGNET_RELEASE: cfg_in.magnet_release_ms = csr_wdata;
            CSR_PLACE_MOVE:     cfg_in.place_move_ms     = csr_wdata;
            CSR_HOME_RETURN:    cfg_in.home_return_ms    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_wait_ms   <= STARTUP_WAIT_RST;
         cfg_ff.pick_move_ms      <= PICK_MOVE_RST;
         cfg_ff.servo_move_ms     <= SERVO_MOVE_RST;
         cfg_ff.magnet_settle_ms  <= MAGNET_SETTLE_RST;
         cfg_ff.magnet_release_ms <= MAGNET_RELEASE_RST;
         cfg_ff.place_move_ms     <= PLACE_MOVE_RST;
         cfg_ff.home_return_ms    <= HOME_RETURN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/tpps_core.sv */
// Input register, sequence state and phase update of the pick-and-place sequencer.
// Depends on tpps_pkg; feeds one result per processed beat to tpps_out.
module tpps_core import tpps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      in_valid,
   input  logic                      in_op,
   input  logic signed [CoordW-1:0]  in_pick_x,
   input  logic signed [CoordW-1:0]  in_pick_y,
   input  logic signed [CoordW-1:0]  in_place_x,
   input  logic signed [CoordW-1:0]  in_place_y,
   output logic                      in_ready,
   input  logic                      res_ready,
   output logic                      res_valid,
   output res_type                   res
);

   // Input register stage.
   logic                     hold_valid_ff, hold_valid_in;
   logic                     hold_op_ff;
   logic signed [CoordW-1:0] hold_pick_x_ff, hold_pick_y_ff;
   logic signed [CoordW-1:0] hold_place_x_ff, hold_place_y_ff;

   // Sequence state.
   phase_type                phase_ff, phase_in;
   logic [MsW-1:0]           elapsed_ff, elapsed_in;
   logic signed [CoordW-1:0] pick_x_ff, pick_y_ff, place_x_ff, place_y_ff;
   logic signed [CoordW-1:0] pick_x_in, pick_y_in, place_x_in, place_y_in;
   logic                     pending_ff, pending_in;
   logic                     home_sent_ff, home_sent_in;

   logic                     fire;
   logic [MsW-1:0]           elapsed_inc;
   act_type                  act;
   logic signed [CoordW-1:0] tx, ty;

   // The held beat is processed when the result stage can take it.
   assign fire     = hold_valid_ff && res_ready;
   assign in_ready = !hold_valid_ff || res_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (in_valid && in_ready) begin
         hold_valid_in = 1'b1;
      end else if (fire) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hold_op_ff      <= in_op;
         hold_pick_x_ff  <= in_pick_x;
         hold_pick_y_ff  <= in_pick_y;
         hold_place_x_ff <= in_place_x;
         hold_place_y_ff <= in_place_y;
      end
   end

   // Saturating millisecond count for this tick.
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + MsW'(1);

   // Phase update for the held beat.
   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      pick_x_in    = pick_x_ff;
      pick_y_in    = pick_y_ff;
      place_x_in   = place_x_ff;
      place_y_in   = place_y_ff;
      pending_in   = pending_ff;
      home_sent_in = home_sent_ff;
      act          = ACT_NONE;
      tx           = '0;
      ty           = '0;
      if (hold_op_ff) begin
         // A command overwrites all coordinates and takes no time.
         pick_x_in  = hold_pick_x_ff;
         pick_y_in  = hold_pick_y_ff;
         place_x_in = hold_place_x_ff;
         place_y_in = hold_place_y_ff;
         pending_in = 1'b1;
      end else if (!home_sent_ff) begin
         // The first tick after reset only sends the arm home.
         home_sent_in = 1'b1;
         act          = ACT_HOME;
         elapsed_in   = '0;
      end else begin
         elapsed_in = elapsed_inc;
         case (phase_ff)
            PH_STARTUP: begin
               if (elapsed_inc >= cfg.startup_wait_ms) phase_in = PH_IDLE;
            end
            PH_IDLE: begin
               if (pending_ff) begin
                  act        = ACT_MOVE;
                  tx         = pick_x_ff;
                  ty         = pick_y_ff;
                  phase_in   = PH_TO_PICK;
                  elapsed_in = '0;
               end
            end
            PH_TO_PICK: begin
               if (elapsed_inc >= cfg.pick_move_ms) phase_in = PH_PICK_AT;
            end
            PH_PICK_AT: begin
               act        = ACT_SERVO_LOW;
               phase_in   = PH_LOWER_PICK;
               elapsed_in = '0;
            end
            PH_LOWER_PICK: begin
               if (elapsed_inc >= cfg.servo_move_ms) begin
                  act        = ACT_MAGNET_ON;
                  phase_in   = PH_MAG_SETTLE;
                  elapsed_in = '0;
               end
            end
            PH_MAG_SETTLE: begin
               if (elapsed_inc >= cfg.magnet_settle_ms) begin
                  act        = ACT_SERVO_HIGH;
                  phase_in   = PH_RAISE_PICK;
                  elapsed_in = '0;
               end
            end
            PH_RAISE_PICK: begin
               if (elapsed_inc >= cfg.servo_move_ms) begin
                  act        = ACT_MOVE;
                  tx         = place_x_ff;
                  ty         = place_y_ff;
                  phase_in   = PH_TO_PLACE;
                  elapsed_in = '0;
               end
            end
            PH_TO_PLACE: begin
               if (elapsed_inc >= cfg.place_move_ms) phase_in = PH_PLACE_AT;
            end
            PH_PLACE_AT: begin
               act        = ACT_SERVO_LOW;
               phase_in   = PH_LOWER_PLACE;
               elapsed_in = '0;
            end
            PH_LOWER_PLACE: begin
               if (elapsed_inc >= cfg.servo_move_ms) begin
                  act        = ACT_MAGNET_OFF;
                  phase_in   = PH_MAG_RELEASE;
                  elapsed_in = '0;
               end
            end
            PH_MAG_RELEASE: begin
               if (elapsed_inc >= cfg.magnet_release_ms) begin
                  act        = ACT_SERVO_HIGH;
                  phase_in   = PH_RAISE_PLACE;
                  elapsed_in = '0;
               end
            end
            PH_RAISE_PLACE: begin
               if (elapsed_inc >= cfg.servo_move_ms) begin
                  act        = ACT_HOME;
                  phase_in   = PH_TO_HOME;
                  elapsed_in = '0;
               end
            end
            PH_TO_HOME: begin
               // The command completes once the arm is back home.
               if (elapsed_inc >= cfg.home_return_ms) begin
                  pending_in = 1'b0;
                  phase_in   = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // State advances only when a beat is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STARTUP;
         elapsed_ff   <= '0;
         pick_x_ff    <= '0;
         pick_y_ff    <= '0;
         place_x_ff   <= '0;
         place_y_ff   <= '0;
         pending_ff   <= 1'b0;
         home_sent_ff <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         pick_x_ff    <= pick_x_in;
         pick_y_ff    <= pick_y_in;
         place_x_ff   <= place_x_in;
         place_y_ff   <= place_y_in;
         pending_ff   <= pending_in;
         home_sent_ff <= home_sent_in;
      end
   end

   // Result for the processed beat.
   assign res_valid     = fire;
   assign res.action    = act;
   assign res.target_x  = tx;
   assign res.target_y  = ty;
   assign res.phase     = phase_num(phase_in);
   assign res.ready_res = (phase_in == PH_IDLE) && !pending_in;

endmodule

/* hdl/tpps_out.sv */
// Result register of the pick-and-place sequencer, driving the rsp_ stream.
// Depends on tpps_pkg for the result type.
module tpps_out import tpps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  res_type res,
   output logic    res_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output res_type out_res
);

   logic    valid_ff, valid_in;
   res_type res_ff;

   // The register takes a new result when empty or drained this cycle.
   assign res_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

/* hdl/timed_pick_place_sequencer_top.sv */
// Timed pick-and-place sequencer: one result beat for every request beat.
// Path: a request beat passes the input register, then the result register.
// Throughput: one beat per cycle; req_tready only drops while a result waits
// on rsp_tready and the input register is also full.
// Reset: synchronous, active high; timing registers return to their defaults,
// the sequence returns to the startup phase and both register stages empty.
module timed_pick_place_sequencer_top import tpps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Request stream.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,  // pick_x, pick_y, place_x, place_y
   input  logic [0:0]         req_tuser,  // op
   // Result stream.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,  // target_x, target_y, phase, ready_res, zero pad
   output logic [2:0]         rsp_tuser,  // action
   // Configuration write port.
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [MsW-1:0]     csr_wdata
);

   cfg_type cfg;
   logic    res_valid, res_ready;
   res_type res, out_res;

   tpps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpps_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_op      (req_tuser[0]),
      .in_pick_x  (req_tdata[15:0]),
      .in_pick_y  (req_tdata[31:16]),
      .in_place_x (req_tdata[47:32]),
      .in_place_y (req_tdata[63:48]),
      .in_ready   (req_tready),
      .res_ready  (res_ready),
      .res_valid  (res_valid),
      .res        (res)
   );

   tpps_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   // Pack the result beat, lowest field first.
   assign rsp_tdata = {3'b000, out_res.ready_res, out_res.phase,
                       out_res.target_y, out_res.target_x};
   assign rsp_tuser = out_res.action;

endmodule

/* hdl/tpps_checker.sv */
// Port-level checker for the timed pick-and-place sequencer, bound to the top.
// Depends on timed_pick_place_sequencer_top_macros.svh for the assertion macros.
`include "timed_pick_place_sequencer_top_macros.svh"

module tpps_checker import tpps_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [39:0]        rsp_tdata,
   input logic [2:0]         rsp_tuser
);

   // Phase numbers as they appear in the result beat.
   localparam logic [PhNumW-1:0] PHN_IDLE     = 4'd1;
   localparam logic [PhNumW-1:0] PHN_TO_PICK  = 4'd2;
   localparam logic [PhNumW-1:0] PHN_TO_PLACE = 4'd7;

   logic [PhNumW-1:0] rsp_phase;
   logic [42:0]       rsp_beat;
   logic              rsp_stall;
   logic              rsp_move;

   // Views of the result stream used by the checks below.
   assign rsp_phase = rsp_tdata[35:32];
   assign rsp_beat  = {rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_move  = rsp_tvalid && (rsp_tuser == ACT_MOVE);

   // A stalled result beat holds its payload.
   `TPPS_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_beat))

   // A draining result stage always leaves room for a new request beat.
   `TPPS_ASSERT_IMP(a_req_room, rsp_tready, req_tready)

   // Ready is only reported in the idle phase.
   `TPPS_ASSERT_IMP(a_ready_idle, rsp_tvalid && rsp_tdata[36], rsp_phase == PHN_IDLE)

   // Targets are zero for every action but a move.
   `TPPS_ASSERT_IMP(a_target_zero, rsp_tvalid && !rsp_move, rsp_tdata[31:0] == 32'd0)

   // A move starts travel to either the pick or the place position.
   `TPPS_ASSERT_IMP(a_move_phase, rsp_move, rsp_phase == PHN_TO_PICK || rsp_phase == PHN_TO_PLACE)

endmodule

bind timed_pick_place_sequencer_top tpps_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
